[sv/rclm_pkg.sv]
// ----------------------------------------------------------------------------
// rclm_pkg
// Shared types and constants for the region cache lookup and merge block.
// ----------------------------------------------------------------------------
package rclm_pkg;

	// default table depth and fixed field widths
	localparam int ENTRIES_DEF = 16;
	localparam int SW          = 48;   // start address width
	localparam int EW          = 49;   // exclusive end address width
	localparam int LW          = 32;   // request length width
	localparam int PSW         = 5;    // page shift width
	localparam logic [PSW-1:0] PAGE_SHIFT_RST = 5'd12;

	// item opcodes
	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;          // capture the request
		logic clear;         // empty the table, zero result
		logic scan_start;    // begin a read pass over the table
		logic scan_walk;     // pass looks for the next region in start order
		logic res_hit;       // result from the covering region
		logic init_walk;     // widen left and seed the walk
		logic absorb_next;   // take the candidate found by the last pass
		logic free_apply;    // drop absorbed entries, align the range
		logic slot_next;     // advance the free slot search
		logic res_full;      // result for a full table
		logic write_new;     // write the merged region
		logic push;          // move the staged result to the output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_done;
		logic hit;
		logic walk_stop;
		logic slot_free;
		logic slot_last;
		logic out_free;
	} status_t;

endpackage

[sv/rclm_ram.sv]
// ----------------------------------------------------------------------------
// rclm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rclm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/rclm_ctrl.sv]
// ----------------------------------------------------------------------------
// rclm_ctrl
// Sequencer for lookup, walk, compaction and result hand-off.
// ----------------------------------------------------------------------------
module rclm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	output logic              in_stall,
	input  rclm_pkg::status_t st,
	output rclm_pkg::cmd_t    cmd
);
	import rclm_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LEFT  = 9'b000000010,
		S_CHECK = 9'b000000100,
		S_WALK  = 9'b000001000,
		S_STEP  = 9'b000010000,
		S_FREE  = 9'b000100000,
		S_SLOT  = 9'b001000000,
		S_WRITE = 9'b010000000,
		S_RES   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (opcode == OP_CLEAR) begin
						cmd.clear = 1'b1;
						state_d   = S_RES;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_LEFT;
					end
				end
			end
			S_LEFT: begin
				if (st.scan_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (st.hit) begin
					cmd.res_hit = 1'b1;
					state_d     = S_RES;
				end else begin
					cmd.init_walk  = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.scan_walk  = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_WALK: begin
				if (st.scan_done) state_d = S_STEP;
			end
			S_STEP: begin
				if (st.walk_stop) begin
					state_d = S_FREE;
				end else begin
					cmd.absorb_next = 1'b1;
					cmd.scan_start  = 1'b1;
					cmd.scan_walk   = 1'b1;
					state_d         = S_WALK;
				end
			end
			S_FREE: begin
				cmd.free_apply = 1'b1;
				state_d        = S_SLOT;
			end
			S_SLOT: begin
				if (st.slot_free) begin
					state_d = S_WRITE;
				end else if (st.slot_last) begin
					cmd.res_full = 1'b1;
					state_d      = S_RES;
				end else begin
					cmd.slot_next = 1'b1;
				end
			end
			S_WRITE: begin
				cmd.write_new = 1'b1;
				state_d       = S_RES;
			end
			S_RES: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/rclm_dp.sv]
// ----------------------------------------------------------------------------
// rclm_dp
// Region table, scan pipeline, merge arithmetic and output register.
// ----------------------------------------------------------------------------
module rclm_dp #(
	parameter int ENTRIES = rclm_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rclm_pkg::PSW-1:0]  cfg_wdata,
	input  logic [rclm_pkg::SW-1:0]   req_start,
	input  logic [rclm_pkg::LW-1:0]   req_length,
	input  rclm_pkg::cmd_t            cmd,
	output rclm_pkg::status_t         st,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic                      hit,
	output logic [3:0]                slot_index,
	output logic [rclm_pkg::SW-1:0]   region_start,
	output logic [rclm_pkg::SW-1:0]   region_length,
	output logic [4:0]                merged_count,
	output logic                      table_full
);
	import rclm_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = SW + EW;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	// length of a region, saturated to the output width
	function automatic logic [SW-1:0] sat_len(input logic [EW-1:0] e, input logic [SW-1:0] s);
		logic [EW:0] d;
		d = {1'b0, e} - {2'b00, s};
		sat_len = (d[EW] || d[EW-1]) ? {SW{1'b1}} : d[SW-1:0];
	endfunction

	// configuration
	logic [PSW-1:0] page_shift_q;

	// request and walk state
	logic [SW-1:0] s_q, ns_q, cs_q;
	logic [EW-1:0] e_q, ne_q;
	logic          have_q;
	logic [IW-1:0] ci_q;
	logic [CW-1:0] cnt_q;

	// candidates from the read passes
	logic          lf_q, nf_q;
	logic [IW-1:0] left_idx_q, n_idx_q;
	logic [SW-1:0] left_start_q, n_start_q;
	logic [EW-1:0] left_end_q, n_end_q;

	// per-slot flags
	logic [ENTRIES-1:0] valid_q, absorb_q;

	// scan pipeline
	logic          scanning_q, walk_q;
	logic [IW-1:0] addr_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	// slot search and aligned range
	logic [IW-1:0] slot_q;
	logic [SW-1:0] as_q;
	logic [EW-1:0] ae_q;

	// staged and output result
	logic          stg_hit, stg_full;
	logic [3:0]    stg_slot;
	logic [SW-1:0] stg_start, stg_len;
	logic [4:0]    stg_cnt;
	logic          out_vld_q;

	// table storage: end in the upper bits, start in the lower
	logic [RW-1:0] rdata;
	logic [SW-1:0] rd_start;
	logic [EW-1:0] rd_end;

	rclm_ram #(
		.WIDTH (RW),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write_new),
		.waddr (slot_q),
		.wdata ({ae_q, as_q}),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign rd_start = rdata[SW-1:0];
	assign rd_end   = rdata[RW-1:SW];

	// candidate tests on the entry returned by the scan
	logic          left_take, walk_after, walk_better, walk_take;
	logic [EW-1:0] pm;
	logic [IW+3:0] slot_ext, left_ext;
	logic [CW+4:0] cnt_ext;

	assign left_take   = valid_q[rd_idx_s1] && (rd_start <= s_q) &&
	                     (!lf_q || rd_start >= left_start_q);
	assign walk_after  = !have_q || (cs_q < rd_start) ||
	                     (cs_q == rd_start && ci_q < rd_idx_s1);
	assign walk_better = !nf_q || (rd_start < n_start_q) ||
	                     (rd_start == n_start_q && rd_idx_s1 < n_idx_q);
	assign walk_take   = valid_q[rd_idx_s1] && walk_after && walk_better;

	assign pm       = ~({EW{1'b1}} << page_shift_q);
	assign slot_ext = {4'b0000, slot_q};
	assign left_ext = {4'b0000, left_idx_q};
	assign cnt_ext  = {5'b00000, cnt_q};

	// status to the controller
	assign st.scan_done = rd_vld_s1 && (rd_idx_s1 == LAST);
	assign st.hit       = lf_q && (left_end_q >= e_q);
	assign st.walk_stop = !nf_q || (ne_q < {1'b0, n_start_q});
	assign st.slot_free = !valid_q[slot_q];
	assign st.slot_last = (slot_q == LAST);
	assign st.out_free  = !out_vld_q || !out_stall;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= PAGE_SHIFT_RST;
			valid_q      <= '0;
			scanning_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) page_shift_q <= cfg_wdata;
			// table occupancy
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (cmd.free_apply) begin
				valid_q <= valid_q & ~absorb_q;
			end else if (cmd.write_new) begin
				valid_q[slot_q] <= 1'b1;
			end
			// read pass sequencing
			if (cmd.scan_start) begin
				scanning_q <= 1'b1;
			end else if (scanning_q && addr_q == LAST) begin
				scanning_q <= 1'b0;
			end
			rd_vld_s1 <= scanning_q;
			// output register
			if (cmd.push) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (cmd.scan_start) begin
			addr_q <= '0;
			walk_q <= cmd.scan_walk;
			if (cmd.scan_walk) nf_q <= 1'b0;
			else lf_q <= 1'b0;
		end else if (scanning_q) begin
			addr_q <= addr_q + IW'(1);
		end

		// candidate updates during a pass
		if (rd_vld_s1 && !walk_q && left_take) begin
			lf_q         <= 1'b1;
			left_idx_q   <= rd_idx_s1;
			left_start_q <= rd_start;
			left_end_q   <= rd_end;
		end
		if (rd_vld_s1 && walk_q && walk_take) begin
			nf_q      <= 1'b1;
			n_idx_q   <= rd_idx_s1;
			n_start_q <= rd_start;
			n_end_q   <= rd_end;
		end

		// request capture
		if (cmd.load) begin
			s_q      <= req_start;
			e_q      <= {1'b0, req_start} + {{(EW-LW){1'b0}}, req_length};
			cnt_q    <= '0;
			absorb_q <= '0;
		end

		// widen to the left and seed the walk
		if (cmd.init_walk) begin
			have_q <= lf_q;
			cs_q   <= left_start_q;
			ci_q   <= left_idx_q;
			if (lf_q && {1'b0, s_q} <= left_end_q) begin
				ns_q                 <= left_start_q;
				ne_q                 <= (left_end_q > e_q) ? left_end_q : e_q;
				absorb_q[left_idx_q] <= 1'b1;
				cnt_q                <= CW'(1);
			end else begin
				ns_q <= s_q;
				ne_q <= e_q;
			end
		end

		// absorb the next region in start order
		if (cmd.absorb_next) begin
			if (n_end_q > ne_q) ne_q <= n_end_q;
			absorb_q[n_idx_q] <= 1'b1;
			cnt_q             <= cnt_q + CW'(1);
			have_q            <= 1'b1;
			cs_q              <= n_start_q;
			ci_q              <= n_idx_q;
		end

		// page alignment and slot search
		if (cmd.free_apply) begin
			slot_q <= '0;
			as_q   <= ns_q & ~pm[SW-1:0];
			ae_q   <= (ne_q + pm) & ~pm;
		end else if (cmd.slot_next) begin
			slot_q <= slot_q + IW'(1);
		end

		// staged result
		if (cmd.clear || cmd.res_full) begin
			stg_hit   <= 1'b0;
			stg_slot  <= '0;
			stg_start <= '0;
			stg_len   <= '0;
			stg_cnt   <= '0;
			stg_full  <= cmd.res_full;
		end else if (cmd.res_hit) begin
			stg_hit   <= 1'b1;
			stg_slot  <= left_ext[3:0];
			stg_start <= left_start_q;
			stg_len   <= sat_len(left_end_q, left_start_q);
			stg_cnt   <= '0;
			stg_full  <= 1'b0;
		end else if (cmd.write_new) begin
			stg_hit   <= 1'b0;
			stg_slot  <= slot_ext[3:0];
			stg_start <= as_q;
			stg_len   <= sat_len(ae_q, as_q);
			stg_cnt   <= cnt_ext[4:0];
			stg_full  <= 1'b0;
		end

		// output payload
		if (cmd.push) begin
			hit           <= stg_hit;
			slot_index    <= stg_slot;
			region_start  <= stg_start;
			region_length <= stg_len;
			merged_count  <= stg_cnt;
			table_full    <= stg_full;
		end
	end

	assign out_valid = out_vld_q;

`ifndef SYNTHESIS
	// a result never overwrites one that is still waiting
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_vld_q || !out_stall))
		else $error("result pushed over a stalled transaction");

	// a new pass never starts while one is still reading
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !scanning_q)
		else $error("read pass restarted while scanning");

	// the walk only absorbs live entries, each at most once
	a_absorb_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.absorb_next |-> (valid_q[n_idx_q] && !absorb_q[n_idx_q]))
		else $error("walk absorbed a free or absorbed slot");

	// a new region lands in a free slot and occupies it afterwards
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_new |-> (!valid_q[slot_q] ##1 valid_q[$past(slot_q)]))
		else $error("new region written over a live slot");
`endif

endmodule

[sv/region_cache_lookup_merge.sv]
// ----------------------------------------------------------------------------
// region_cache_lookup_merge
// Registered address region table with lookup, merge and clear.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Every lookup first reads the whole
// table from RAM, one slot a cycle, and a hit result is then staged from the
// covering region and moved to the output register once that is free. A miss
// walks the regions in start order with one further full read pass per region
// absorbed to the right of the request start plus a closing pass, then
// searches the valid bits for the lowest free slot, or reports a full table
// when none is free, before its result is loaded. A clear empties the table
// and loads a zero result once the output register is free. The single read
// port of the region RAM is why each pass reads one slot a cycle. The next
// transaction is taken in the cycle after the result is loaded into the output
// register, even while that result is stalled.
module region_cache_lookup_merge #(
	parameter int ENTRIES = rclm_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [rclm_pkg::PSW-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [rclm_pkg::SW-1:0]  req_start,
	input  logic [rclm_pkg::LW-1:0]  req_length,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [3:0]               slot_index,
	output logic [rclm_pkg::SW-1:0]  region_start,
	output logic [rclm_pkg::SW-1:0]  region_length,
	output logic [4:0]               merged_count,
	output logic                     table_full
);
	import rclm_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer
	rclm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// table and merge datapath
	rclm_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_start     (req_start),
		.req_length    (req_length),
		.cmd           (cmd),
		.st            (st),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.hit           (hit),
		.slot_index    (slot_index),
		.region_start  (region_start),
		.region_length (region_length),
		.merged_count  (merged_count),
		.table_full    (table_full)
	);

endmodule
